### rtl/core/first_fit_seat_allocator_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit seat allocator core.
// Each check is written once and compiles away when NO_ASSERTIONS is set.
// The macros expect a clock named clk and a reset named rst in the module.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_SEAT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SEAT_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsa: same-cycle check failed");
`define FSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsa: next-cycle check failed");
`else
`define FSA_ASSERT_IMP(lbl, ante, cons)
`define FSA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/fsa_pkg.sv
// ---------------------------------------------------------------------------
// First-fit seat allocator package
// Shared constants, state encoding and the command and status bundles
// exchanged between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

  localparam int MAX_SEATS_DEF  = 1024;
  localparam int OWNER_BITS_DEF = 16;

  localparam int SEAT_CNT_W = 11;
  localparam int REQ_W      = 11;
  localparam int ACT_W      = 2;

  localparam logic [SEAT_CNT_W-1:0] SEAT_COUNT_RST = 11'd1024;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_SEAT_COUNT = 1'b0;

  localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_run;
    logic scan_run;
    logic fill_run;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic grant_ok;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/fsa_datapath.sv
// ---------------------------------------------------------------------------
// First-fit seat allocator datapath
// Holds the seat store, the scan and fill counters, the run tracking, the
// configuration register and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fsa_datapath import fsa_pkg::*; #(
  parameter int MAX_SEATS  = MAX_SEATS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [OWNER_BITS-1:0] owner_id,
  input  wire logic [REQ_W-1:0]      request_size,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       granted
);

  localparam int IDX_W = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
  localparam int CNT_W = $clog2(MAX_SEATS + 1);
  localparam int CMP_W = (CNT_W > SEAT_CNT_W) ? CNT_W : SEAT_CNT_W;

  logic [OWNER_BITS-1:0] mem [MAX_SEATS];
  logic [OWNER_BITS-1:0] rdata;

  logic [SEAT_CNT_W-1:0] seat_count;
  logic [CNT_W-1:0]      used;

  logic [ACT_W-1:0]      action_r;
  logic [OWNER_BITS-1:0] who;
  logic [REQ_W-1:0]      want;

  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_inc;
  logic             dup;
  logic             found;
  logic [IDX_W-1:0] fill_idx;
  logic [IDX_W-1:0] end_idx;
  logic [CMP_W-1:0] start_w;

  logic                  issue;
  logic                  rel_hit;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [OWNER_BITS-1:0] wdata;
  logic                  grant_val;
  logic                  cfg_wr;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seat_count <= SEAT_COUNT_RST;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_SEAT_COUNT)) begin
      seat_count <= pwdata[SEAT_CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_SEAT_COUNT) begin
      prdata = PDATA_W'(seat_count);
    end
  end

  assign used = (CMP_W'(seat_count) > CMP_W'(MAX_SEATS)) ? CNT_W'(MAX_SEATS)
                                                          : CNT_W'(seat_count);

  assign issue   = cmd.scan_run && (scan_idx != used);
  assign rel_hit = cmd.scan_run && rd_vld && (action_r == ACT_RELEASE) && (rdata == who);
  assign run_inc = run + CNT_W'(1);
  assign start_w = CMP_W'(rd_idx) + CMP_W'(1) - CMP_W'(want);

  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = '0;
    if (cmd.clr_run) begin
      we = 1'b1;
    end else if (cmd.fill_run) begin
      we    = 1'b1;
      waddr = fill_idx;
      wdata = who;
    end else if (rel_hit) begin
      we    = 1'b1;
      waddr = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[scan_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      who      <= owner_id;
      want     <= request_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_run) begin
      clr_idx <= status.clr_last ? '0 : clr_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      dup      <= 1'b0;
      found    <= 1'b0;
      run      <= '0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
      dup      <= 1'b0;
      found    <= 1'b0;
      run      <= '0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (rd_vld && (rdata == who)) begin
        dup <= 1'b1;
      end
      if (rd_vld && !found) begin
        if (rdata == '0) begin
          run <= run_inc;
          if (CMP_W'(run_inc) == CMP_W'(want)) begin
            found <= 1'b1;
          end
        end else begin
          run <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[IDX_W-1:0];
    if (rd_vld && !found && (rdata == '0) && (CMP_W'(run_inc) == CMP_W'(want))) begin
      end_idx  <= rd_idx;
      fill_idx <= start_w[IDX_W-1:0];
    end else if (cmd.fill_run) begin
      fill_idx <= fill_idx + IDX_W'(1);
    end
  end

  always_comb begin
    case (action_r) inside
      ACT_RESERVE:            grant_val = !dup && found;
      ACT_RELEASE, ACT_CLEAR: grant_val = 1'b1;
      default:                grant_val = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      granted <= grant_val;
    end
  end

  assign status.clr_last  = (clr_idx == IDX_W'(MAX_SEATS - 1));
  assign status.scan_done = (scan_idx == used) && !rd_vld;
  assign status.grant_ok  = (action_r == ACT_RESERVE) && !dup && found;
  assign status.fill_last = (fill_idx == end_idx);
  assign status.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

### rtl/core/fsa_ctrl.sv
// ---------------------------------------------------------------------------
// First-fit seat allocator controller
// Sequences the clearing pass, the store scan, the seat fill and the
// hand-over of each result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "first_fit_seat_allocator_core_macros.svh"

module fsa_ctrl import fsa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ACT_W-1:0] action,
  input  wire status_t          status,
  output cmd_t                  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        cmd.clr_run = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (action) inside
            ACT_RESERVE, ACT_RELEASE: state_next = ST_SCAN;
            ACT_CLEAR:                state_next = ST_CLEAR;
            default:                  state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (status.clr_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = status.grant_ok ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill_run = 1'b1;
        if (status.fill_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  `FSA_ASSERT_IMP(a_load_when_free, cmd.result_load, status.out_free)
  `FSA_ASSERT_IMP(a_fill_only_granted, state == ST_FILL, status.grant_ok)
  `FSA_ASSERT_NXT(a_accept_leaves_idle, (state == ST_IDLE) && in_valid, state != ST_IDLE)

endmodule

`default_nettype wire

### rtl/core/first_fit_seat_allocator_core.sv
// From an accepted item to a valid result: a reserve or a release scans the seats in use
// (seat_count capped at MAX_SEATS), and a granted reserve then fills request_size seats;
// a clear writes every seat of the store, and an unused action goes straight to the result.
// One item at a time: the result registers once the output is free, and only then is the next item taken.
// Reset: a clearing pass over all MAX_SEATS seats follows reset, with no item accepted meanwhile.
// seat_count returns to 1024 on reset; configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// First-fit seat allocator core
// Top level joining the sequencing controller to the seat store datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_seat_allocator_core import fsa_pkg::*; #(
  parameter int MAX_SEATS  = MAX_SEATS_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic      [PDATA_W-1:0]    prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ACT_W-1:0]      action,
  input  wire logic [OWNER_BITS-1:0] owner_id,
  input  wire logic [REQ_W-1:0]      request_size,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       granted
);

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  fsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  fsa_datapath #(
    .MAX_SEATS  (MAX_SEATS),
    .OWNER_BITS (OWNER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .action       (action),
    .owner_id     (owner_id),
    .request_size (request_size),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted      (granted)
  );

endmodule

`default_nettype wire
